// ----- hdl/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its condition
`define PBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its condition
`define PBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pbc_pkg.sv -----
`timescale 1ns / 1ps

package pbc_pkg;

  // request queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // operating modes as seen on out_mode
  localparam logic [1:0] MODE_ENTRY = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_DONE  = 2'd2;
  localparam logic [1:0] MODE_EMERG = 2'd3;

  // input command codes
  localparam logic [1:0] CMD_BUTTON = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // decoded key codes, digits are 0..KEY_DIGIT_MAX
  localparam logic [4:0] KEY_DIGIT_MAX = 5'd9;
  localparam logic [4:0] KEY_A         = 5'd10;
  localparam logic [4:0] KEY_B         = 5'd11;
  localparam logic [4:0] KEY_C         = 5'd12;
  localparam logic [4:0] KEY_D         = 5'd13;
  localparam logic [4:0] KEY_STAR      = 5'd14;
  localparam logic [4:0] KEY_HASH      = 5'd15;
  localparam logic [4:0] KEY_NONE      = 5'd16;

  // limits and reset values
  localparam logic [5:0] COUNT_MAX   = 6'd59;
  localparam logic [6:0] ENTRY_MAX   = 7'd99;
  localparam logic [7:0] IDLE_MAX    = 8'hFF;
  localparam logic [7:0] DIM_RESET   = 8'd10;
  localparam logic [7:0] SLEEP_RESET = 8'd20;
  localparam logic [2:0] COLOR_EMERG = 3'd1;

  // configuration register indexes (paddr[2])
  localparam logic REG_DIM   = 1'b0;
  localparam logic REG_SLEEP = 1'b1;

  // request class produced by the front end
  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_BUTTON,
    REQ_KEY,
    REQ_TICK
  } pbc_kind_t;

  typedef struct packed {
    pbc_kind_t  kind;
    logic       level;
    logic [4:0] code;
  } pbc_req_t;

  // lamp pair: units digit and tens color
  typedef struct packed {
    logic [3:0] unit;
    logic [2:0] color;
  } pbc_lamp_t;

  // keypad position to key code, row-major layout
  function automatic logic [4:0] key_code(logic [4:0] pos);
    logic [4:0] code;
    case (pos)
      5'd1:    code = 5'd1;
      5'd2:    code = 5'd2;
      5'd3:    code = 5'd3;
      5'd4:    code = KEY_A;
      5'd5:    code = 5'd4;
      5'd6:    code = 5'd5;
      5'd7:    code = 5'd6;
      5'd8:    code = KEY_B;
      5'd9:    code = 5'd7;
      5'd10:   code = 5'd8;
      5'd11:   code = 5'd9;
      5'd12:   code = KEY_C;
      5'd13:   code = KEY_STAR;
      5'd14:   code = 5'd0;
      5'd15:   code = KEY_HASH;
      5'd16:   code = KEY_D;
      default: code = KEY_NONE;
    endcase
    return code;
  endfunction

  // tens digit to rgb lamp code
  function automatic logic [2:0] tens_color(logic [2:0] tens);
    logic [2:0] color;
    case (tens)
      3'd0:    color = 3'b101;
      3'd1:    color = 3'b100;
      3'd2:    color = 3'b110;
      3'd3:    color = 3'b010;
      3'd4:    color = 3'b011;
      3'd5:    color = 3'b111;
      default: color = 3'b000;
    endcase
    return color;
  endfunction

  // split a count into lamp outputs; tens by reciprocal multiply (x*205)>>11
  function automatic pbc_lamp_t show_count(logic [5:0] cnt);
    logic [13:0] prod;
    logic [2:0]  tens;
    logic [5:0]  tens_x10;
    logic [5:0]  unit;
    pbc_lamp_t   lamp;
    prod     = {8'd0, cnt} * 14'd205;
    tens     = prod[13:11];
    tens_x10 = {tens, 3'b000} - {2'b00, tens, 1'b0} + {1'b0, tens, 2'b00};
    unit     = cnt - tens_x10;
    lamp.unit  = unit[3:0];
    lamp.color = tens_color(tens);
    return lamp;
  endfunction

endpackage

// ----- hdl/preset_batch_counter_control.sv -----
`timescale 1ns / 1ps

// Preset batch counter control: takes button samples, keypad presses and
// 100 ms ticks, one request per cycle while in_stall is low, and returns
// one result per request with the mode, entry, target, count, lamp and
// display status after that request. The front end decodes the keypad
// position and classifies the request into a short queue; the back end
// applies one request per cycle, unless a stalled result holds it, to the
// state registers, which also form the result register. Sustained rate is
// one request per clock while the result side is not stalled; a request
// passes through the queue into the state registers. in_stall rises only
// once the queue (QUEUE_DEPTH entries) has filled behind a stalled result.
// dim_after_ticks sits at byte address 0 and sleep_after_ticks at 4;
// write them only while no request is in flight.
module preset_batch_counter_control #(
  parameter int QUEUE_DEPTH = pbc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_button_level,
  input  logic [4:0]  in_key_position,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_mode,
  output logic [6:0]  out_entry_value,
  output logic [5:0]  out_target_value,
  output logic [5:0]  out_count_value,
  output logic [5:0]  out_remaining,
  output logic [3:0]  out_unit_digit,
  output logic [2:0]  out_color_code,
  output logic        out_backlight_on,
  output logic        out_asleep,
  output logic        out_range_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        dim_after_ticks_r;
  logic [7:0]        sleep_after_ticks_r;
  logic              cfg_write;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  pbc_pkg::pbc_req_t front_req;
  pbc_pkg::pbc_req_t back_req;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_ticks_r   <= pbc_pkg::DIM_RESET;
      sleep_after_ticks_r <= pbc_pkg::SLEEP_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        pbc_pkg::REG_DIM:   dim_after_ticks_r   <= pwdata[7:0];
        pbc_pkg::REG_SLEEP: sleep_after_ticks_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pbc_pkg::REG_DIM:   prdata = {24'd0, dim_after_ticks_r};
      pbc_pkg::REG_SLEEP: prdata = {24'd0, sleep_after_ticks_r};
      default:            prdata = '0;
    endcase
  end

  // request decode
  pbc_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_button_level (in_button_level),
    .in_key_position (in_key_position),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_req           (front_req)
  );

  // request queue
  pbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (back_req)
  );

  // state update and result
  pbc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .dim_after_ticks   (dim_after_ticks_r),
    .sleep_after_ticks (sleep_after_ticks_r),
    .q_valid           (q_not_empty),
    .q_req             (back_req),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode          (out_mode),
    .out_entry_value   (out_entry_value),
    .out_target_value  (out_target_value),
    .out_count_value   (out_count_value),
    .out_remaining     (out_remaining),
    .out_unit_digit    (out_unit_digit),
    .out_color_code    (out_color_code),
    .out_backlight_on  (out_backlight_on),
    .out_asleep        (out_asleep),
    .out_range_error   (out_range_error)
  );

endmodule

// ----- hdl/pbc_front.sv -----
`timescale 1ns / 1ps

module pbc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_command,
  input  logic             in_button_level,
  input  logic [4:0]       in_key_position,
  input  logic             q_full,
  output logic             q_push,
  output pbc_pkg::pbc_req_t q_req
);

  logic [4:0] code;

  // request handshake toward the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // key decode
  assign code = pbc_pkg::key_code(in_key_position);

  // classify the request
  always_comb begin
    q_req.level = in_button_level;
    q_req.code  = code;
    case (in_command)
      pbc_pkg::CMD_BUTTON: q_req.kind = pbc_pkg::REQ_BUTTON;
      pbc_pkg::CMD_KEY: begin
        q_req.kind = (code == pbc_pkg::KEY_NONE) ? pbc_pkg::REQ_NONE : pbc_pkg::REQ_KEY;
      end
      pbc_pkg::CMD_TICK:   q_req.kind = pbc_pkg::REQ_TICK;
      default:             q_req.kind = pbc_pkg::REQ_NONE;
    endcase
  end

endmodule

// ----- hdl/pbc_queue.sv -----
`timescale 1ns / 1ps

module pbc_queue #(
  parameter int DEPTH = pbc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbc_pkg::pbc_req_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pbc_pkg::pbc_req_t pop_data
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  pbc_pkg::pbc_req_t entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign full      = (fill_r == FILL_W'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  // pointer wrap and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/pbc_back.sv -----
`timescale 1ns / 1ps

module pbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        dim_after_ticks,
  input  logic [7:0]        sleep_after_ticks,
  input  logic              q_valid,
  input  pbc_pkg::pbc_req_t q_req,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_mode,
  output logic [6:0]        out_entry_value,
  output logic [5:0]        out_target_value,
  output logic [5:0]        out_count_value,
  output logic [5:0]        out_remaining,
  output logic [3:0]        out_unit_digit,
  output logic [2:0]        out_color_code,
  output logic              out_backlight_on,
  output logic              out_asleep,
  output logic              out_range_error
);

  typedef enum logic [1:0] {
    ST_ENTRY = pbc_pkg::MODE_ENTRY,
    ST_COUNT = pbc_pkg::MODE_COUNT,
    ST_DONE  = pbc_pkg::MODE_DONE,
    ST_EMERG = pbc_pkg::MODE_EMERG
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [6:0] entry_r, entry_nxt;
  logic [5:0] target_r, target_nxt;
  logic [5:0] count_r, count_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       backlight_r, backlight_nxt;
  logic       sleep_r, sleep_nxt;
  logic       button_prev_r, button_prev_nxt;
  logic [3:0] unit_r, unit_nxt;
  logic [2:0] color_r, color_nxt;
  logic [5:0] remaining_r, remaining_nxt;
  logic       range_error_r, range_error_nxt;
  logic       out_valid_r;

  logic [5:0]        count_inc;
  logic [7:0]        idle_inc;
  logic [9:0]        entry_digit;
  logic [14:0]       entry_prod;
  logic [6:0]        entry_shift;
  pbc_pkg::pbc_lamp_t lamp_now, lamp_inc, lamp_zero;

  // take the next request whenever the output slot frees up
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // shared arithmetic
  assign count_inc   = (count_r < pbc_pkg::COUNT_MAX) ? count_r + 6'd1 : count_r;
  assign idle_inc    = (idle_r < pbc_pkg::IDLE_MAX) ? idle_r + 8'd1 : idle_r;
  assign entry_digit = {entry_r, 3'b000} + {2'b00, entry_r, 1'b0} + {5'd0, q_req.code};
  assign entry_prod  = {8'd0, entry_r} * 15'd205;
  assign entry_shift = {3'b000, entry_prod[14:11]};
  assign lamp_now    = pbc_pkg::show_count(count_r);
  assign lamp_inc    = pbc_pkg::show_count(count_inc);
  assign lamp_zero   = pbc_pkg::show_count(6'd0);

  // one request step
  always_comb begin
    mode_nxt        = mode_r;
    entry_nxt       = entry_r;
    target_nxt      = target_r;
    count_nxt       = count_r;
    idle_nxt        = idle_r;
    backlight_nxt   = backlight_r;
    sleep_nxt       = sleep_r;
    button_prev_nxt = button_prev_r;
    unit_nxt        = unit_r;
    color_nxt       = color_r;
    range_error_nxt = 1'b0;
    if (mode_r != ST_EMERG) begin
      case (q_req.kind)
        pbc_pkg::REQ_BUTTON: begin
          if (!sleep_r) begin
            if (q_req.level && !button_prev_r) begin
              idle_nxt = '0;
              if (mode_r == ST_COUNT) begin
                count_nxt = count_inc;
                unit_nxt  = lamp_inc.unit;
                color_nxt = lamp_inc.color;
                if (count_inc >= target_r) begin
                  mode_nxt = ST_DONE;
                end
              end
            end
            button_prev_nxt = q_req.level;
          end
        end
        pbc_pkg::REQ_KEY: begin
          idle_nxt = '0;
          // wake up before handling the key
          if (sleep_r) begin
            sleep_nxt     = 1'b0;
            backlight_nxt = 1'b1;
            if (mode_r == ST_COUNT) begin
              unit_nxt  = lamp_now.unit;
              color_nxt = lamp_now.color;
            end
          end
          if (q_req.code == pbc_pkg::KEY_HASH && mode_r == ST_ENTRY) begin
            if (entry_r != 7'd0 && entry_r <= {1'b0, pbc_pkg::COUNT_MAX}) begin
              target_nxt = entry_r[5:0];
              count_nxt  = '0;
              entry_nxt  = '0;
              mode_nxt   = ST_COUNT;
              unit_nxt   = lamp_zero.unit;
              color_nxt  = lamp_zero.color;
            end else begin
              range_error_nxt = 1'b1;
              entry_nxt       = '0;
            end
          end else if (q_req.code == pbc_pkg::KEY_D) begin
            mode_nxt  = ST_EMERG;
            color_nxt = pbc_pkg::COLOR_EMERG;
          end else begin
            if (q_req.code == pbc_pkg::KEY_C) begin
              backlight_nxt = !backlight_nxt;
            end
            case (mode_r)
              ST_ENTRY: begin
                if (q_req.code <= pbc_pkg::KEY_DIGIT_MAX) begin
                  entry_nxt = (entry_digit > {3'b000, pbc_pkg::ENTRY_MAX}) ?
                              7'd0 : entry_digit[6:0];
                end else if (q_req.code == pbc_pkg::KEY_STAR) begin
                  entry_nxt = entry_shift;
                end
              end
              ST_COUNT: begin
                if (q_req.code == pbc_pkg::KEY_B || q_req.code == pbc_pkg::KEY_A) begin
                  count_nxt = '0;
                  unit_nxt  = lamp_zero.unit;
                  color_nxt = lamp_zero.color;
                  if (q_req.code == pbc_pkg::KEY_B) begin
                    mode_nxt = ST_DONE;
                  end
                end
              end
              ST_DONE: begin
                if (q_req.code == pbc_pkg::KEY_HASH) begin
                  mode_nxt  = ST_ENTRY;
                  entry_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
        pbc_pkg::REQ_TICK: begin
          if (!sleep_r) begin
            idle_nxt = idle_inc;
            if (idle_inc == dim_after_ticks) begin
              backlight_nxt = 1'b0;
            end
            if (idle_inc >= sleep_after_ticks) begin
              unit_nxt      = '0;
              color_nxt     = '0;
              backlight_nxt = 1'b0;
              sleep_nxt     = 1'b1;
              idle_nxt      = '0;
            end
          end
        end
        default: ;
      endcase
    end
    remaining_nxt = (target_nxt > count_nxt) ? target_nxt - count_nxt : 6'd0;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ST_ENTRY;
      entry_r       <= '0;
      target_r      <= '0;
      count_r       <= '0;
      idle_r        <= '0;
      backlight_r   <= 1'b1;
      sleep_r       <= 1'b0;
      button_prev_r <= 1'b0;
      unit_r        <= '0;
      color_r       <= '0;
      remaining_r   <= '0;
      range_error_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (q_pop) begin
      mode_r        <= mode_nxt;
      entry_r       <= entry_nxt;
      target_r      <= target_nxt;
      count_r       <= count_nxt;
      idle_r        <= idle_nxt;
      backlight_r   <= backlight_nxt;
      sleep_r       <= sleep_nxt;
      button_prev_r <= button_prev_nxt;
      unit_r        <= unit_nxt;
      color_r       <= color_nxt;
      remaining_r   <= remaining_nxt;
      range_error_r <= range_error_nxt;
      out_valid_r   <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields straight from state
  assign out_valid        = out_valid_r;
  assign out_mode         = mode_r;
  assign out_entry_value  = entry_r;
  assign out_target_value = target_r;
  assign out_count_value  = count_r;
  assign out_remaining    = remaining_r;
  assign out_unit_digit   = unit_r;
  assign out_color_code   = color_r;
  assign out_backlight_on = backlight_r;
  assign out_asleep       = sleep_r;
  assign out_range_error  = range_error_r;

endmodule

// ----- hdl/pbc_checker.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_mode,
  input logic [6:0] out_entry_value,
  input logic [3:0] out_unit_digit,
  input logic [2:0] out_color_code,
  input logic       out_backlight_on,
  input logic       out_asleep,
  input logic       out_range_error
);

  // a stalled result stays offered
  `PBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

  // emergency is a lock until reset
  `PBC_ASSERT_NEXT(a_emerg_lock, clk, rst_n, out_valid && out_mode == pbc_pkg::MODE_EMERG, !out_valid || out_mode == pbc_pkg::MODE_EMERG, "left emergency mode")

  // a rejected target stays in entry mode with a cleared entry
  `PBC_ASSERT_SAME(a_range_err, clk, rst_n, out_valid && out_range_error, out_mode == pbc_pkg::MODE_ENTRY && out_entry_value == 7'd0, "range error outside entry")

  // sleeping means dark display and cleared lamps
  `PBC_ASSERT_SAME(a_sleep_dark, clk, rst_n, out_valid && out_asleep, !out_backlight_on && out_unit_digit == 4'd0 && out_color_code == 3'd0, "lamps lit while asleep")

endmodule

bind preset_batch_counter_control pbc_checker u_pbc_checker (.*);

// ----- tb/tb_preset_batch_counter_control.sv -----
`timescale 1ns / 1ps

module tb_preset_batch_counter_control;

  // keypad positions, row-major
  localparam logic [4:0] POS_A    = 5'd4;
  localparam logic [4:0] POS_B    = 5'd8;
  localparam logic [4:0] POS_C    = 5'd12;
  localparam logic [4:0] POS_STAR = 5'd13;
  localparam logic [4:0] POS_HASH = 5'd15;
  localparam logic [4:0] POS_D    = 5'd16;

  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0] command;
    logic       level;
    logic [4:0] position;
    logic       drain;
  } req_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] entry;
    logic [5:0] target;
    logic [5:0] count;
    logic [5:0] remaining;
    logic [3:0] unit;
    logic [2:0] color;
    logic       backlight;
    logic       asleep;
    logic       range_error;
  } display_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = pbc_pkg::CMD_BUTTON;
  logic        in_button_level = 1'b0;
  logic [4:0]  in_key_position = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_mode;
  logic [6:0]  out_entry_value;
  logic [5:0]  out_target_value;
  logic [5:0]  out_count_value;
  logic [5:0]  out_remaining;
  logic [3:0]  out_unit_digit;
  logic [2:0]  out_color_code;
  logic        out_backlight_on;
  logic        out_asleep;
  logic        out_range_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  preset_batch_counter_control i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_button_level  (in_button_level),
    .in_key_position  (in_key_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_entry_value  (out_entry_value),
    .out_target_value (out_target_value),
    .out_count_value  (out_count_value),
    .out_remaining    (out_remaining),
    .out_unit_digit   (out_unit_digit),
    .out_color_code   (out_color_code),
    .out_backlight_on (out_backlight_on),
    .out_asleep       (out_asleep),
    .out_range_error  (out_range_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t     request_q[$];
  display_t display_q[$];
  logic     in_taken = 1'b0;
  int       cycles = 0;
  int       errors = 0;
  int       queued = 0;
  int       accepted = 0;
  int       results = 0;
  int       settings = 1;
  int       sleeps = 0;
  int       wakes = 0;
  int       rejects = 0;
  int       completions = 0;

  // predicted block state
  logic [1:0] sim_mode;
  logic [6:0] sim_entry;
  logic [5:0] sim_target;
  logic [5:0] sim_count;
  logic [7:0] sim_idle;
  logic       sim_light;
  logic       sim_asleep;
  logic       sim_btn;
  logic [3:0] sim_unit;
  logic [2:0] sim_color;
  logic [7:0] sim_dim_at;
  logic [7:0] sim_sleep_at;

  function automatic logic [2:0] tens_lamp(int tens);
    case (tens)
      0: return 3'd5;
      1: return 3'd4;
      2: return 3'd6;
      3: return 3'd2;
      4: return 3'd3;
      5: return 3'd7;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [4:0] decode_key(logic [4:0] pos);
    case (pos)
      5'd1: return 5'd1;
      5'd2: return 5'd2;
      5'd3: return 5'd3;
      5'd4: return pbc_pkg::KEY_A;
      5'd5: return 5'd4;
      5'd6: return 5'd5;
      5'd7: return 5'd6;
      5'd8: return pbc_pkg::KEY_B;
      5'd9: return 5'd7;
      5'd10: return 5'd8;
      5'd11: return 5'd9;
      5'd12: return pbc_pkg::KEY_C;
      5'd13: return pbc_pkg::KEY_STAR;
      5'd14: return 5'd0;
      5'd15: return pbc_pkg::KEY_HASH;
      5'd16: return pbc_pkg::KEY_D;
      default: return pbc_pkg::KEY_NONE;
    endcase
  endfunction

  function automatic logic [4:0] digit_pos(int d);
    case (d)
      0: return 5'd14;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd3;
      4: return 5'd5;
      5: return 5'd6;
      6: return 5'd7;
      7: return 5'd9;
      8: return 5'd10;
      default: return 5'd11;
    endcase
  endfunction

  function automatic void lamps_from_count();
    sim_unit  = 4'(sim_count % 10);
    sim_color = tens_lamp(sim_count / 10);
  endfunction

  function automatic void clear_state();
    sim_mode     = pbc_pkg::MODE_ENTRY;
    sim_entry    = '0;
    sim_target   = '0;
    sim_count    = '0;
    sim_idle     = '0;
    sim_light    = 1'b1;
    sim_asleep   = 1'b0;
    sim_btn      = 1'b0;
    sim_unit     = '0;
    sim_color    = '0;
    sim_dim_at   = pbc_pkg::DIM_RESET;
    sim_sleep_at = pbc_pkg::SLEEP_RESET;
  endfunction

  // display and status after one request
  function automatic display_t next_display(req_t r);
    logic [4:0] code;
    logic       rejected;
    int         typed;
    display_t   d;
    rejected = 1'b0;
    if (sim_mode != pbc_pkg::MODE_EMERG) begin
      if (r.command == pbc_pkg::CMD_BUTTON && !sim_asleep) begin
        // rising edge of the count button
        if (r.level && !sim_btn) begin
          sim_idle = '0;
          if (sim_mode == pbc_pkg::MODE_COUNT) begin
            if (sim_count < pbc_pkg::COUNT_MAX) sim_count = sim_count + 6'd1;
            lamps_from_count();
            if (sim_count >= sim_target) begin
              sim_mode = pbc_pkg::MODE_DONE;
              completions++;
            end
          end
        end
        sim_btn = r.level;
      end else if (r.command == pbc_pkg::CMD_KEY) begin
        code = decode_key(r.position);
        if (code != pbc_pkg::KEY_NONE) begin
          sim_idle = '0;
          // any valid key wakes the display
          if (sim_asleep) begin
            sim_asleep = 1'b0;
            sim_light  = 1'b1;
            wakes++;
            if (sim_mode == pbc_pkg::MODE_COUNT) lamps_from_count();
          end
          if (code == pbc_pkg::KEY_HASH && sim_mode == pbc_pkg::MODE_ENTRY) begin
            if (sim_entry >= 1 && sim_entry <= pbc_pkg::COUNT_MAX) begin
              sim_target = sim_entry[5:0];
              sim_count  = '0;
              sim_entry  = '0;
              sim_mode   = pbc_pkg::MODE_COUNT;
              lamps_from_count();
            end else begin
              rejected  = 1'b1;
              sim_entry = '0;
              rejects++;
            end
          end else if (code == pbc_pkg::KEY_D) begin
            sim_mode  = pbc_pkg::MODE_EMERG;
            sim_color = pbc_pkg::COLOR_EMERG;
          end else begin
            if (code == pbc_pkg::KEY_C) sim_light = ~sim_light;
            if (sim_mode == pbc_pkg::MODE_ENTRY) begin
              if (code <= pbc_pkg::KEY_DIGIT_MAX) begin
                typed = int'(sim_entry) * 10 + int'(code);
                sim_entry = (typed > int'(pbc_pkg::ENTRY_MAX)) ? 7'd0 : typed[6:0];
              end else if (code == pbc_pkg::KEY_STAR) begin
                sim_entry = 7'(sim_entry / 10);
              end
            end else if (sim_mode == pbc_pkg::MODE_COUNT) begin
              if (code == pbc_pkg::KEY_A || code == pbc_pkg::KEY_B) begin
                sim_count = '0;
                lamps_from_count();
                if (code == pbc_pkg::KEY_B) begin
                  sim_mode = pbc_pkg::MODE_DONE;
                  completions++;
                end
              end
            end else if (sim_mode == pbc_pkg::MODE_DONE && code == pbc_pkg::KEY_HASH) begin
              sim_mode  = pbc_pkg::MODE_ENTRY;
              sim_entry = '0;
            end
          end
        end
      end else if (r.command == pbc_pkg::CMD_TICK && !sim_asleep) begin
        // idle tick: dim, then sleep
        if (sim_idle != pbc_pkg::IDLE_MAX) sim_idle = sim_idle + 8'd1;
        if (sim_idle == sim_dim_at) sim_light = 1'b0;
        if (sim_idle >= sim_sleep_at) begin
          sim_unit   = '0;
          sim_color  = '0;
          sim_light  = 1'b0;
          sim_asleep = 1'b1;
          sim_idle   = '0;
          sleeps++;
        end
      end
    end
    d.mode        = sim_mode;
    d.entry       = sim_entry;
    d.target      = sim_target;
    d.count       = sim_count;
    d.remaining   = (sim_target > sim_count) ? sim_target - sim_count : 6'd0;
    d.unit        = sim_unit;
    d.color       = sim_color;
    d.backlight   = sim_light;
    d.asleep      = sim_asleep;
    d.range_error = rejected;
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results, what, got, want);
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles, %0d results outstanding", cycles, display_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver, bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    req_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && display_q.size() != 0)) begin
        nxt = request_q.pop_front();
        in_command      <= nxt.command;
        in_button_level <= nxt.level;
        in_key_position <= nxt.position;
        in_valid        <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 8);
          gap_left   = $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  stall_style_t stall_style = STALL_NONE;
  int           stall_run = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_run   = $urandom_range(10, 60);
    end
    stall_run--;
    case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (cycles % 7 >= 4);
      default:        out_stall <= 1'b0;
    endcase
  end

  // accept requests, predict, and check results
  always @(posedge clk) begin
    req_t     r;
    display_t got;
    display_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      r.command  = in_command;
      r.level    = in_button_level;
      r.position = in_key_position;
      r.drain    = 1'b0;
      display_q.push_back(next_display(r));
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.mode        = out_mode;
      got.entry       = out_entry_value;
      got.target      = out_target_value;
      got.count       = out_count_value;
      got.remaining   = out_remaining;
      got.unit        = out_unit_digit;
      got.color       = out_color_code;
      got.backlight   = out_backlight_on;
      got.asleep      = out_asleep;
      got.range_error = out_range_error;
      if (display_q.size() == 0) begin
        report_mismatch("result with nothing pending, mode", got.mode, 0);
      end else begin
        want = display_q.pop_front();
        check_field("mode", got.mode, want.mode);
        check_field("entry_value", got.entry, want.entry);
        check_field("target_value", got.target, want.target);
        check_field("count_value", got.count, want.count);
        check_field("remaining", got.remaining, want.remaining);
        check_field("unit_digit", got.unit, want.unit);
        check_field("color_code", got.color, want.color);
        check_field("backlight_on", got.backlight, want.backlight);
        check_field("asleep", got.asleep, want.asleep);
        check_field("range_error", got.range_error, want.range_error);
      end
      results++;
    end
  end

  // stimulus helpers
  task automatic push_item(logic [1:0] cmd, logic lvl, logic [4:0] pos, bit drain = 1'b0);
    req_t r;
    r.command  = cmd;
    r.level    = lvl;
    r.position = pos;
    r.drain    = drain;
    request_q.push_back(r);
    queued++;
  endtask

  task automatic push_key(logic [4:0] pos, bit drain = 1'b0);
    push_item(pbc_pkg::CMD_KEY, 1'($urandom_range(0, 1)), pos, drain);
  endtask

  task automatic push_button(logic lvl);
    push_item(pbc_pkg::CMD_BUTTON, lvl, 5'($urandom_range(0, 31)));
  endtask

  task automatic push_ticks(int n);
    repeat (n) begin
      push_item(pbc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    end
  endtask

  task automatic push_value(int v);
    if (v >= 10) push_key(digit_pos(v / 10));
    push_key(digit_pos(v % 10));
  endtask

  // anything except the emergency key
  task automatic add_noise();
    logic [4:0] pos;
    pos = 5'($urandom_range(0, 30));
    if (pos >= POS_D) pos = pos + 5'd1;
    push_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pos);
  endtask

  // one batch: type a target, count presses with interruptions, return to entry
  task automatic add_batch();
    int goal;
    int presses;
    int pick;
    int roll;
    pick = $urandom_range(0, 19);
    if (pick < 10) goal = $urandom_range(1, 9);
    else if (pick < 14) goal = $urandom_range(10, 59);
    else if (pick == 14) goal = 1;
    else if (pick == 15) goal = 59;
    else if (pick == 16) goal = 0;
    else goal = $urandom_range(60, 99);
    if ($urandom_range(0, 5) == 0) begin
      push_key(digit_pos($urandom_range(0, 9)));
      push_key(POS_STAR);
    end
    push_value(goal);
    if ($urandom_range(0, 7) == 0) begin
      push_key(digit_pos($urandom_range(0, 9)));
      push_key(POS_STAR);
    end
    push_key(POS_HASH, $urandom_range(0, 5) == 0);
    if (goal == 0 || goal > 59) presses = $urandom_range(0, 3);
    else presses = $urandom_range(0, 1) ? goal + 1 : $urandom_range(0, goal + 2);
    for (int i = 0; i < presses; i++) begin
      push_button(1'b1);
      if ($urandom_range(0, 5) == 0) push_button(1'b1);
      push_button(1'b0);
      roll = $urandom_range(0, 29);
      if (roll < 3) push_ticks($urandom_range(1, 3));
      else if (roll == 3) push_key(POS_A);
      else if (roll == 4) push_key(POS_C);
      else if (roll == 5) push_key(POS_B);
      else if (roll == 6) add_noise();
    end
    // idle ticks that may reach sleep, button samples, then a key that wakes a sleeping display
    if (sim_sleep_at <= 40 && $urandom_range(0, 3) == 0) begin
      push_ticks($urandom_range(1, sim_sleep_at + 1));
      push_button(1'b1);
      push_ticks(1);
      push_button(1'b0);
      push_key(5'($urandom_range(1, 15)));
    end
    push_key(POS_HASH);
  endtask

  task automatic add_random(int n);
    int start;
    start = queued;
    while (queued - start < n) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_batch();
    end
  endtask

  // short directed opening at reset settings
  task automatic add_directed();
    push_button(1'b0);
    push_button(1'b1);
    push_item(CMD_UNUSED, 1'b1, 5'd31);
    push_key(5'd0);
    push_key(5'd31);
    push_key(5'd17);
    push_key(POS_HASH);
    push_key(digit_pos(9));
    push_key(digit_pos(9));
    push_key(digit_pos(9));
    push_value(60);
    push_key(POS_HASH);
    push_key(digit_pos(1));
    push_key(POS_STAR);
    push_value(59);
    push_key(POS_HASH);
    push_button(1'b0);
    push_button(1'b1);
    push_key(POS_A);
    push_key(POS_C);
    push_key(POS_B);
    push_key(POS_HASH, 1'b1);
  endtask

  // wait until every request is out and checked
  task automatic settle();
    while (request_q.size() != 0 || in_valid || display_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == pbc_pkg::REG_DIM) sim_dim_at = value;
    else sim_sleep_at = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd != {24'd0, value}) report_mismatch("register readback", rd, value);
  endtask

  task automatic set_timing(logic [7:0] dim_at, logic [7:0] sleep_at);
    settle();
    cfg_write(pbc_pkg::REG_DIM, dim_at);
    cfg_write(pbc_pkg::REG_SLEEP, sleep_at);
    settings++;
  endtask

  // main sequence
  initial begin
    clear_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_directed();
    add_random(20);

    set_timing(8'd1, 8'd255);
    push_ticks(256);
    add_random(20);

    set_timing(8'd255, 8'd1);
    add_random(20);

    set_timing(8'd3, 8'd6);
    add_random(20);

    set_timing(8'd255, 8'd255);
    add_random(20);

    set_timing(8'd1, 8'd1);
    add_random(20);

    // emergency lock, everything after it is ignored
    push_key(POS_D);
    push_button(1'b0);
    push_button(1'b1);
    push_key(POS_HASH);
    push_key(POS_C);
    push_key(POS_D);
    repeat (8) add_noise();
    settle();

    $display("covered %0d requests, %0d results, %0d timing settings", accepted, results,
             settings);
    $display("%0d sleeps, %0d wake-ups, %0d rejected targets, %0d finished batches", sleeps,
             wakes, rejects, completions);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pbc_pkg.sv
hdl/pbc_front.sv
hdl/pbc_queue.sv
hdl/pbc_back.sv
hdl/preset_batch_counter_control.sv
hdl/pbc_checker.sv
tb/tb_preset_batch_counter_control.sv
